// ----- design/pcol_pkg.sv -----
`timescale 1ns / 1ps
// pcol_pkg: shared types and constants for the primitive collision test.
// No dependencies; imported by pcol_axis, primitive_collision_test and tb_top.
package pcol_pkg;

  // Width of every packed body field on the ports (x, y, z lanes).
  localparam int unsigned FieldBits = 48;

  // Collider kind codes.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_BOX    = 2'd2;

  // Offsets from the nearest box point at or beyond 2^MagBits are a miss,
  // so every squared term fits in SqBits.
  localparam int unsigned MagBits = 30;
  localparam int unsigned SqBits  = 2 * MagBits;
  localparam int unsigned SumBits = SqBits + 2;

  // Shift that brings squared Q8.8 radii up to the Q16.16 offset scale.
  localparam int unsigned ScaleShift = 16;

  typedef enum logic [1:0] {
    PAIR_NONE   = 2'd0,
    PAIR_SPHERE = 2'd1,
    PAIR_BOX    = 2'd2,
    PAIR_MIXED  = 2'd3
  } pair_case_e;

  typedef struct packed {
    logic       valid;
    pair_case_e pc;
  } stage_ctl_t;

endpackage

// ----- design/pcol_axis.sv -----
`timescale 1ns / 1ps
// pcol_axis: per-axis datapath (difference, box product, clamp, square),
// three register stages deep. Depends on pcol_pkg.
module pcol_axis import pcol_pkg::*; #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                        clk_i,
  input  logic signed [CoordBits-1:0] cp_i,
  input  logic signed [CoordBits-1:0] cq_i,
  input  logic signed [CoordBits-1:0] sp_i,
  input  logic signed [CoordBits-1:0] sq_i,
  input  logic signed [CoordBits-1:0] eq_i,
  input  logic                        sphere_pair_i,
  output logic                        box_ok_o,
  output logic                        far_o,
  output logic [SqBits-1:0]           sq_dist_o
);

  localparam int unsigned DiffW  = CoordBits + 1;
  localparam int unsigned ProdW  = 2 * CoordBits;
  localparam int unsigned ScW    = CoordBits + 9;
  localparam int unsigned ClampW = ProdW + 1;
  localparam int unsigned WideW  = (ScW > ClampW) ? ScW : ClampW;
  localparam int unsigned TW     = WideW + 1;

  // Stage A: difference, box half extent product, summed sizes.
  logic signed [DiffW-1:0] diff_d, diff_q;
  logic signed [ProdW-1:0] ext_d, ext_q;
  logic signed [DiffW-1:0] bsum_d, bsum_q;

  assign diff_d = DiffW'(cp_i) - DiffW'(cq_i);
  assign ext_d  = ProdW'(sq_i) * ProdW'(eq_i);
  assign bsum_d = DiffW'(sp_i) + DiffW'(sq_i);

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    ext_q  <= ext_d;
    bsum_q <= bsum_d;
  end

  // Stage B: box compare, clamp to the box, pick the value to square.
  logic [DiffW-1:0]     dmag;
  logic signed [DiffW:0] dmag_s;
  logic signed [TW-1:0] dsc, ew, new_e, c1, c2, tdist;
  logic [TW-1:0]        tmag;
  logic                 box_ok_d, box_ok_q, far_d, far_q;
  logic [MagBits-1:0]   vmag_d, vmag_q;

  always_comb begin
    dmag     = diff_q[DiffW-1] ? DiffW'(-diff_q) : DiffW'(diff_q);
    dmag_s   = $signed({1'b0, dmag});
    box_ok_d = dmag_s < (DiffW + 1)'(bsum_q);
    dsc      = TW'(diff_q) <<< 8;
    ew       = TW'(ext_q);
    new_e    = -ew;
    c1       = (dsc < new_e) ? new_e : dsc;
    c2       = (c1 > ew) ? ew : c1;
    tdist    = dsc - c2;
    tmag     = tdist[TW-1] ? TW'(-tdist) : TW'(tdist);
    far_d    = 64'(tmag) >= (64'(1) << MagBits);
    vmag_d   = sphere_pair_i ? MagBits'(dmag) : MagBits'(tmag);
  end

  always_ff @(posedge clk_i) begin
    box_ok_q <= box_ok_d;
    far_q    <= far_d;
    vmag_q   <= vmag_d;
  end

  // Stage C: square.
  logic [SqBits-1:0] sq_d, sq_q;
  logic              box_ok_c_q, far_c_q;

  assign sq_d = SqBits'(vmag_q) * SqBits'(vmag_q);

  always_ff @(posedge clk_i) begin
    sq_q       <= sq_d;
    box_ok_c_q <= box_ok_q;
    far_c_q    <= far_q;
  end

  assign sq_dist_o = sq_q;
  assign box_ok_o  = box_ok_c_q;
  assign far_o     = far_c_q;

endmodule

// ----- design/primitive_collision_test.sv -----
`timescale 1ns / 1ps
// primitive_collision_test: top level of the two-body overlap test.
// Depends on pcol_pkg and pcol_axis.
//
// Usage:
//   Command channel: drive kind_*, centre_*, size_* and extent_* with
//   start_i high; the beat is taken at any rising edge where busy_o is low.
//   busy_o is always low: the pipeline takes one pair every cycle.
//   Result channel: done_o is high for exactly one cycle and carries hit_o
//   and pair_case_o for that beat. The receiver cannot hold results off,
//   and none is needed, since nothing inside ever waits.
//   Result path: five register stages (decode, difference/product, clamp,
//   square, sum-and-compare) lie between a taken beat and its result.
//   Throughput: one pair per cycle, set by the single squarer per axis
//   that every pair passes through once.
//   Reset (rst_ni low, asynchronous) drops every beat in flight; done_o
//   stays low until new beats arrive. Payload registers are not reset.
//   Sphere-sphere and sphere-box pairs share the per-axis squarers: the
//   value squared is the centre difference or the offset from the nearest
//   box point, chosen by pair case.
module primitive_collision_test import pcol_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           kind_a_i,
  input  logic [1:0]           kind_b_i,
  input  logic [FieldBits-1:0] centre_a_i,
  input  logic [FieldBits-1:0] centre_b_i,
  input  logic [FieldBits-1:0] size_a_i,
  input  logic [FieldBits-1:0] size_b_i,
  input  logic [FieldBits-1:0] extent_a_i,
  input  logic [FieldBits-1:0] extent_b_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [1:0]           pair_case_o
);

  localparam int unsigned PackBits = 3 * COORD_BITS;
  localparam int unsigned PadW     = (PackBits > FieldBits) ? PackBits : FieldBits;
  localparam int unsigned DiffW    = COORD_BITS + 1;
  localparam int unsigned R2W      = 2 * DiffW;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------
  // Stage 1: decode the pair, put the sphere first for mixed pairs, and
  // unpack the lanes. Bits above 3*COORD_BITS are ignored; missing bits
  // above the 48-bit field read as zero.
  // ---------------------------------------------------------------------
  pair_case_e pc_d;
  logic       swap;
  logic [PadW-1:0] cen_p, cen_q, siz_p, siz_q, ext_q_pk;
  logic signed [COORD_BITS-1:0] cp_d [3], cq_d [3], sp_d [3], sq_d [3], eq_d [3];
  logic signed [COORD_BITS-1:0] cp_q [3], cq_q [3], sp_q [3], sq_q [3], eq_q [3];

  always_comb begin
    pc_d = PAIR_NONE;
    swap = 1'b0;
    if (kind_a_i == KIND_SPHERE && kind_b_i == KIND_SPHERE) begin
      pc_d = PAIR_SPHERE;
    end else if (kind_a_i == KIND_BOX && kind_b_i == KIND_BOX) begin
      pc_d = PAIR_BOX;
    end else if (kind_a_i == KIND_SPHERE && kind_b_i == KIND_BOX) begin
      pc_d = PAIR_MIXED;
    end else if (kind_a_i == KIND_BOX && kind_b_i == KIND_SPHERE) begin
      pc_d = PAIR_MIXED;
      swap = 1'b1;
    end
  end

  // Every test is symmetric in the two bodies, so always swapping the
  // box-then-sphere order is safe; only the second body's extent is used.
  always_comb begin
    cen_p    = swap ? PadW'(centre_b_i) : PadW'(centre_a_i);
    cen_q    = swap ? PadW'(centre_a_i) : PadW'(centre_b_i);
    siz_p    = swap ? PadW'(size_b_i)   : PadW'(size_a_i);
    siz_q    = swap ? PadW'(size_a_i)   : PadW'(size_b_i);
    ext_q_pk = swap ? PadW'(extent_a_i) : PadW'(extent_b_i);
    for (int k = 0; k < 3; k++) begin
      cp_d[k] = cen_p[k*COORD_BITS +: COORD_BITS];
      cq_d[k] = cen_q[k*COORD_BITS +: COORD_BITS];
      sp_d[k] = siz_p[k*COORD_BITS +: COORD_BITS];
      sq_d[k] = siz_q[k*COORD_BITS +: COORD_BITS];
      eq_d[k] = ext_q_pk[k*COORD_BITS +: COORD_BITS];
    end
  end

  // Control travels with the data down the pipe.
  stage_ctl_t s1_q, s2_q, s3_q, s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '{valid: 1'b0, pc: PAIR_NONE};
      s2_q <= '{valid: 1'b0, pc: PAIR_NONE};
      s3_q <= '{valid: 1'b0, pc: PAIR_NONE};
      s4_q <= '{valid: 1'b0, pc: PAIR_NONE};
    end else begin
      s1_q <= '{valid: accept, pc: pc_d};
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      cp_q[k] <= cp_d[k];
      cq_q[k] <= cq_d[k];
      sp_q[k] <= sp_d[k];
      sq_q[k] <= sq_d[k];
      eq_q[k] <= eq_d[k];
    end
  end

  // ---------------------------------------------------------------------
  // Stages 2 to 4, per axis: difference and box product, clamp and box
  // compare, then the shared squarer.
  // ---------------------------------------------------------------------
  logic              box_ok [3];
  logic              far    [3];
  logic [SqBits-1:0] sq_dist [3];

  for (genvar g = 0; g < 3; g++) begin : g_axis
    pcol_axis #(
      .CoordBits(COORD_BITS)
    ) u_axis (
      .clk_i        (clk_i),
      .cp_i         (cp_q[g]),
      .cq_i         (cq_q[g]),
      .sp_i         (sp_q[g]),
      .sq_i         (sq_q[g]),
      .eq_i         (eq_q[g]),
      .sphere_pair_i(s2_q.pc == PAIR_SPHERE),
      .box_ok_o     (box_ok[g]),
      .far_o        (far[g]),
      .sq_dist_o    (sq_dist[g])
    );
  end

  // Radius path alongside the axes: summed radii for two spheres, the
  // sphere's own radius for a mixed pair.
  logic signed [DiffW-1:0] rad_d, rad_q;
  logic [DiffW-1:0]        rmag_d, rmag_q;
  logic [R2W-1:0]          r2_d, r2_q;

  assign rad_d  = (s1_q.pc == PAIR_SPHERE) ? DiffW'(sp_q[0]) + DiffW'(sq_q[0])
                                           : DiffW'(sp_q[0]);
  assign rmag_d = rad_q[DiffW-1] ? DiffW'(-rad_q) : DiffW'(rad_q);
  assign r2_d   = R2W'(rmag_q) * R2W'(rmag_q);

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rmag_q <= rmag_d;
    r2_q   <= r2_d;
  end

  // ---------------------------------------------------------------------
  // Stage 5: sum the squares, compare, register the result beat.
  // ---------------------------------------------------------------------
  logic [SumBits-1:0] sq_sum, lim;
  logic               hit_d, hit_q, done_q;
  pair_case_e         pc_out_q;

  always_comb begin
    sq_sum = SumBits'(sq_dist[0]) + SumBits'(sq_dist[1]) + SumBits'(sq_dist[2]);
    lim    = (s4_q.pc == PAIR_MIXED) ? (SumBits'(r2_q) << ScaleShift) : SumBits'(r2_q);
    case (s4_q.pc)
      PAIR_SPHERE: hit_d = sq_sum <= lim;
      PAIR_BOX:    hit_d = box_ok[0] && box_ok[1] && box_ok[2];
      PAIR_MIXED:  hit_d = !(far[0] || far[1] || far[2]) && (sq_sum <= lim);
      default:     hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s4_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    pc_out_q <= s4_q.pc;
  end

  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign pair_case_o = pc_out_q;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for primitive_collision_test; predicts hit and
// pair case per body pair and checks each result beat. Depends on pcol_pkg and primitive_collision_test.
module tb_top;
  import pcol_pkg::*;

  localparam int CoordBits     = 16;
  localparam int ResultLatency = 5;        // decode .. compare, five stages
  localparam int CycleLimit    = 200000;
  localparam int ReportCap     = 50;       // keep the log short on a broken block

  // Kind code the block must treat as "no collider" (no package name exists).
  localparam logic [1:0] KindSpare = 2'd3;

  // Offsets at or past 2^30 (Q16.16) from the nearest box point always miss.
  localparam longint MissMag = longint'(1) << 30;

  // Indexed by lane style in rand_lane.
  localparam int StyleFull   = 0;
  localparam int StyleCentre = 1;
  localparam int StyleSize   = 2;
  localparam int StyleExtent = 3;
  localparam int StyleCorner = 4;
  localparam int StyleMixed  = -1;

  typedef struct {
    logic [1:0]           kind_a;
    logic [1:0]           kind_b;
    logic [FieldBits-1:0] centre_a;
    logic [FieldBits-1:0] centre_b;
    logic [FieldBits-1:0] size_a;
    logic [FieldBits-1:0] size_b;
    logic [FieldBits-1:0] extent_a;
    logic [FieldBits-1:0] extent_b;
  } body_pair_t;

  typedef struct {
    logic       hit;
    pair_case_e pc;
  } verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [1:0]           kind_a_i = '0;
  logic [1:0]           kind_b_i = '0;
  logic [FieldBits-1:0] centre_a_i = '0;
  logic [FieldBits-1:0] centre_b_i = '0;
  logic [FieldBits-1:0] size_a_i = '0;
  logic [FieldBits-1:0] size_b_i = '0;
  logic [FieldBits-1:0] extent_a_i = '0;
  logic [FieldBits-1:0] extent_b_i = '0;
  logic                 done_o;
  logic                 hit_o;
  logic [1:0]           pair_case_o;

  body_pair_t pairs_pending[$];   // filled by the stimulus block, drained by the driver
  verdict_t   verdicts_due[$];    // predictions for accepted beats, oldest first
  body_pair_t pair_on_bus;
  int         idle_pct = 20;
  int         pairs_queued = 0;
  int         results_seen = 0;
  int         errors = 0;
  int         cycles = 0;
  int         tested[4] = '{default: 0};
  int         hits[4] = '{default: 0};

  primitive_collision_test #(
    .COORD_BITS(CoordBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .kind_a_i   (kind_a_i),
    .kind_b_i   (kind_b_i),
    .centre_a_i (centre_a_i),
    .centre_b_i (centre_b_i),
    .size_a_i   (size_a_i),
    .size_b_i   (size_b_i),
    .extent_a_i (extent_a_i),
    .extent_b_i (extent_b_i),
    .done_o     (done_o),
    .hit_o      (hit_o),
    .pair_case_o(pair_case_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Overlap predictor
  // ---------------------------------------------------------------------------

  // Pull one signed Q8.8 lane (x=0, y=1, z=2) out of a packed field.
  function automatic longint lane(input logic [FieldBits-1:0] f, input int axis);
    logic signed [CoordBits-1:0] v;
    v = f[axis*CoordBits +: CoordBits];
    return longint'(v);
  endfunction

  // Sphere against box: clamp the Q16.16 offset to the half extents
  // e = size * extent, then compare the squared gap with the squared radius.
  function automatic logic sphere_box_overlap(input logic [FieldBits-1:0] s_centre,
                                              input logic [FieldBits-1:0] s_size,
                                              input logic [FieldBits-1:0] b_centre,
                                              input logic [FieldBits-1:0] b_size,
                                              input logic [FieldBits-1:0] b_ext);
    longint d, e, c, gap, sq_sum;
    int     ax;
    sq_sum = 0;
    for (ax = 0; ax < 3; ax++) begin
      d = (lane(s_centre, ax) - lane(b_centre, ax)) * 256;
      e = lane(b_size, ax) * lane(b_ext, ax);
      // A negative half extent lands on e whatever the offset.
      c = d;
      if (c < -e) c = -e;
      if (c > e) c = e;
      gap = d - c;
      if (gap < 0) gap = -gap;
      if (gap >= MissMag) return 1'b0;
      sq_sum += gap * gap;
    end
    return sq_sum <= ((lane(s_size, 0) * lane(s_size, 0)) << 16);
  endfunction

  function automatic verdict_t predict_overlap(input body_pair_t p);
    verdict_t v;
    longint   sq_sum, diff, span;
    int       ax;
    v.hit = 1'b0;
    v.pc  = PAIR_NONE;
    if (p.kind_a == KIND_SPHERE && p.kind_b == KIND_SPHERE) begin
      // Touching spheres count as a hit.
      v.pc = PAIR_SPHERE;
      sq_sum = 0;
      for (ax = 0; ax < 3; ax++) begin
        diff = lane(p.centre_a, ax) - lane(p.centre_b, ax);
        sq_sum += diff * diff;
      end
      span = lane(p.size_a, 0) + lane(p.size_b, 0);
      v.hit = (sq_sum <= span * span);
    end else if (p.kind_a == KIND_BOX && p.kind_b == KIND_BOX) begin
      // Boxes need strict overlap on every axis.
      v.pc  = PAIR_BOX;
      v.hit = 1'b1;
      for (ax = 0; ax < 3; ax++) begin
        diff = lane(p.centre_a, ax) - lane(p.centre_b, ax);
        if (diff < 0) diff = -diff;
        span = lane(p.size_a, ax) + lane(p.size_b, ax);
        if (!(diff < span)) v.hit = 1'b0;
      end
    end else if (p.kind_a == KIND_SPHERE && p.kind_b == KIND_BOX) begin
      v.pc  = PAIR_MIXED;
      v.hit = sphere_box_overlap(p.centre_a, p.size_a, p.centre_b, p.size_b, p.extent_b);
    end else if (p.kind_a == KIND_BOX && p.kind_b == KIND_SPHERE) begin
      v.pc  = PAIR_MIXED;
      v.hit = sphere_box_overlap(p.centre_b, p.size_b, p.centre_a, p.size_a, p.extent_a);
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [FieldBits-1:0] xyz(input int x, input int y, input int z);
    logic [CoordBits-1:0] lx, ly, lz;
    lx = x[CoordBits-1:0];
    ly = y[CoordBits-1:0];
    lz = z[CoordBits-1:0];
    return {lz, ly, lx};
  endfunction

  function automatic logic [CoordBits-1:0] rand_lane(input int style);
    int v;
    case (style)
      StyleCentre: v = $urandom_range(0, 2048) - 1024;        // within +-4.0
      StyleSize: begin
        v = $urandom_range(0, 1024);                           // 0 .. 4.0
        if ($urandom_range(0, 9) == 0) v = -v;
      end
      StyleExtent: v = $urandom_range(0, 512);                 // 0 .. 2.0
      StyleCorner: begin
        case ($urandom_range(0, 5))
          0:       v = 0;
          1:       v = 1;
          2:       v = -1;
          3:       v = 32767;
          4:       v = -32768;
          default: v = 256;
        endcase
      end
      default: v = $urandom_range(0, 65535);
    endcase
    return v[CoordBits-1:0];
  endfunction

  // A negative style picks the lane style at random per lane.
  function automatic logic [FieldBits-1:0] rand_field(input int style);
    logic [FieldBits-1:0] f;
    int                   ax;
    for (ax = 0; ax < 3; ax++)
      f[ax*CoordBits +: CoordBits] = rand_lane(style < 0 ? $urandom_range(0, 4) : style);
    return f;
  endfunction

  task automatic queue_pair(input logic [1:0] ka, input logic [1:0] kb,
                            input logic [FieldBits-1:0] ca, input logic [FieldBits-1:0] cb,
                            input logic [FieldBits-1:0] sa, input logic [FieldBits-1:0] sb,
                            input logic [FieldBits-1:0] ea, input logic [FieldBits-1:0] eb);
    body_pair_t p;
    p.kind_a   = ka;
    p.kind_b   = kb;
    p.centre_a = ca;
    p.centre_b = cb;
    p.size_a   = sa;
    p.size_b   = sb;
    p.extent_a = ea;
    p.extent_b = eb;
    pairs_pending.push_back(p);
    pairs_queued++;
  endtask

  // Mostly close-range pairs of real colliders so hits and misses both show
  // up; the rest spans the full lane range, corner values, and odd kinds.
  task automatic queue_random(input int count);
    logic [1:0] ka, kb;
    int         n, pick, cs, ss, es;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        ka = KIND_SPHERE; kb = KIND_SPHERE;
      end else if (pick < 44) begin
        ka = KIND_BOX; kb = KIND_BOX;
      end else if (pick < 62) begin
        ka = KIND_SPHERE; kb = KIND_BOX;
      end else if (pick < 80) begin
        ka = KIND_BOX; kb = KIND_SPHERE;
      end else begin
        ka = 2'($urandom_range(0, 3));
        kb = 2'($urandom_range(0, 3));
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        cs = StyleCentre; ss = StyleSize; es = StyleExtent;
      end else if (pick < 85) begin
        cs = StyleFull; ss = StyleFull; es = StyleFull;
      end else begin
        cs = StyleMixed; ss = StyleMixed; es = StyleMixed;
      end
      queue_pair(ka, kb, rand_field(cs), rand_field(cs), rand_field(ss), rand_field(ss),
                 rand_field(es), rand_field(es));
    end
  endtask

  // Hold the stimulus until every queued pair has produced its result.
  task automatic wait_drained();
    while (results_seen < pairs_queued) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present one pair per beat, idle at random, hold while busy
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      // The pair on the bus was taken at this edge: record its prediction.
      if (start_i && !busy_o) verdicts_due.push_back(predict_overlap(pair_on_bus));
      // Advance only when the bus is free; otherwise hold the current beat.
      if (!start_i || !busy_o) begin
        if (pairs_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          pair_on_bus = pairs_pending.pop_front();
          start_i    <= 1'b1;
          kind_a_i   <= pair_on_bus.kind_a;
          kind_b_i   <= pair_on_bus.kind_b;
          centre_a_i <= pair_on_bus.centre_a;
          centre_b_i <= pair_on_bus.centre_b;
          size_a_i   <= pair_on_bus.size_a;
          size_b_i   <= pair_on_bus.size_b;
          extent_a_i <= pair_on_bus.extent_a;
          extent_b_i <= pair_on_bus.extent_b;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done beat must match the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_results
    verdict_t want;
    if (rst_ni) begin
      if ($isunknown(done_o)) begin
        if (errors < ReportCap) $display("%0t: done_o is unknown", $time);
        errors++;
      end else if (done_o) begin
        if (verdicts_due.size() == 0) begin
          if (errors < ReportCap)
            $display("%0t: unexpected result, hit %0d case %0d", $time, hit_o, pair_case_o);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          results_seen++;
          if (hit_o !== want.hit) begin
            if (errors < ReportCap)
              $display("%0t: hit expected %0d, actual %0d (case %0d)", $time, want.hit,
                       hit_o, want.pc);
            errors++;
          end
          if (pair_case_o !== want.pc) begin
            if (errors < ReportCap)
              $display("%0t: pair_case expected %0d, actual %0d", $time, want.pc,
                       pair_case_o);
            errors++;
          end
          tested[want.pc]++;
          if (want.hit) hits[want.pc]++;
        end
      end
    end
  end

  // Watchdog: drop out with a failure if the run stalls.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, verdicts_due.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Colliders that must not be tested: none, the spare code, one-sided.
    queue_pair(KIND_NONE, KIND_NONE, '0, '0, '0, '0, '0, '0);
    queue_pair(KindSpare, KIND_SPHERE, '1, '1, '1, '1, '1, '1);
    queue_pair(KIND_SPHERE, KIND_NONE, '0, '0, xyz(256, 0, 0), xyz(256, 0, 0), '0, '0);
    queue_pair(KIND_BOX, KindSpare, '0, '0, xyz(256, 256, 256), xyz(256, 256, 256),
               xyz(256, 256, 256), xyz(256, 256, 256));
    queue_pair(KIND_NONE, KIND_BOX, '0, '0, '1, '1, '1, '1);

    // Sphere pairs: exact touch, just apart, negative radii, extremes.
    queue_pair(KIND_SPHERE, KIND_SPHERE, xyz(0, 0, 0), xyz(768, 1024, 0),
               xyz(640, 0, 0), xyz(640, 0, 0), '0, '0);
    queue_pair(KIND_SPHERE, KIND_SPHERE, xyz(0, 0, 0), xyz(768, 1024, 0),
               xyz(640, 0, 0), xyz(639, 0, 0), '0, '0);
    queue_pair(KIND_SPHERE, KIND_SPHERE, xyz(0, 0, 0), xyz(768, 1024, 0),
               xyz(-640, 0, 0), xyz(-640, 0, 0), '0, '0);
    queue_pair(KIND_SPHERE, KIND_SPHERE, xyz(32767, 32767, 32767), xyz(-32768, -32768, -32768),
               xyz(32767, 32767, 32767), xyz(32767, 32767, 32767), '1, '1);
    queue_pair(KIND_SPHERE, KIND_SPHERE, xyz(-32768, -32768, -32768),
               xyz(-32768, -32768, -32768), '0, '0, '0, '0);

    // Box pairs: touching face misses, one LSB inside hits, negative and zero
    // sizes, extreme separation.
    queue_pair(KIND_BOX, KIND_BOX, xyz(0, 0, 0), xyz(512, 0, 0),
               xyz(256, 256, 256), xyz(256, 256, 256), '0, '0);
    queue_pair(KIND_BOX, KIND_BOX, xyz(0, 0, 0), xyz(511, -511, 0),
               xyz(256, 256, 256), xyz(256, 256, 256), '0, '0);
    queue_pair(KIND_BOX, KIND_BOX, '0, '0, xyz(-1, -1, -1), xyz(-1, -1, -1), '1, '1);
    queue_pair(KIND_BOX, KIND_BOX, '0, '0, '0, '0, '0, '0);
    queue_pair(KIND_BOX, KIND_BOX, xyz(32767, -32768, 32767), xyz(-32768, 32767, -32768),
               xyz(32767, 32767, 32767), xyz(32767, 32767, 32767), '0, '0);

    // Sphere against box in both orders: exact touch, just out, inside,
    // negative half extent, huge offset, all-ones and most-negative lanes.
    queue_pair(KIND_SPHERE, KIND_BOX, xyz(512, 0, 0), xyz(0, 0, 0),
               xyz(256, 0, 0), xyz(256, 256, 256), '0, xyz(256, 256, 256));
    queue_pair(KIND_BOX, KIND_SPHERE, xyz(0, 0, 0), xyz(512, 0, 0),
               xyz(256, 256, 256), xyz(256, 0, 0), xyz(256, 256, 256), '0);
    queue_pair(KIND_SPHERE, KIND_BOX, xyz(512, 0, 0), xyz(0, 0, 0),
               xyz(255, 0, 0), xyz(256, 256, 256), '0, xyz(256, 256, 256));
    queue_pair(KIND_SPHERE, KIND_BOX, xyz(10, 20, -30), xyz(0, 0, 0),
               xyz(0, 0, 0), xyz(256, 256, 256), '0, xyz(256, 256, 256));
    queue_pair(KIND_BOX, KIND_SPHERE, xyz(0, 0, 0), xyz(0, 0, 0),
               xyz(256, 256, 256), xyz(256, 0, 0), xyz(-256, 256, 256), '0);
    queue_pair(KIND_SPHERE, KIND_BOX, xyz(32767, 0, 0), xyz(-32768, 0, 0),
               xyz(32767, 0, 0), xyz(-32768, 256, 256), '0, xyz(32767, 256, 256));
    queue_pair(KIND_BOX, KIND_SPHERE, '1, '1, '1, '1, '1, '1);
    queue_pair(KIND_SPHERE, KIND_BOX, xyz(-32768, -32768, -32768), xyz(-32768, -32768, -32768),
               xyz(-32768, -32768, -32768), xyz(-32768, -32768, -32768),
               xyz(-32768, -32768, -32768), xyz(-32768, -32768, -32768));

    // Pause the sender until the directed results are all back.
    wait_drained();

    queue_random(700);
    wait_drained();

    // Back-to-back stretch: no idle cycles at all.
    idle_pct = 0;
    queue_random(400);
    wait_drained();

    idle_pct = 20;
    queue_random(700);
    wait_drained();

    // Let any stray beat still in the pipeline surface before judging.
    repeat (ResultLatency * 4) @(posedge clk_i);

    $display("covered %0d pairs: sphere-sphere %0d (%0d hits), box-box %0d (%0d hits),",
             results_seen, tested[PAIR_SPHERE], hits[PAIR_SPHERE], tested[PAIR_BOX],
             hits[PAIR_BOX]);
    $display("  sphere-box %0d (%0d hits), untested %0d", tested[PAIR_MIXED],
             hits[PAIR_MIXED], tested[PAIR_NONE]);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
